### rtl/hvac_irfe_pkg.sv
package hvac_irfe_pkg;

   localparam int FrameBytes = 35;
   localparam int AddrW      = 6;
   localparam int IdxW       = 9;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_NEXT  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      PROTO_LONG        = 2'd0,
      PROTO_NIBBLE      = 2'd1,
      PROTO_MIRROR      = 2'd2,
      PROTO_UNSUPPORTED = 2'd3
   } proto_type;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   typedef struct packed {
      cmd_type            cmd;
      proto_type          protocol;
      logic               power_on;
      logic [7:0]         mode_code;
      logic [7:0]         fan_code;
      logic signed [15:0] target_centi_c;
      logic [7:0]         variant_model;
   } req_type;

   typedef struct packed {
      logic [13:0] mark_us;
      logic [14:0] off_us;
      logic        last;
      logic        status;
   } rsp_type;

   // memory write port from the frame writer
   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   // one decoded symbol: data symbols pick space1 when the frame bit xor inv is set
   typedef struct packed {
      logic [13:0]      mark;
      logic [14:0]      space0;
      logic [14:0]      space1;
      logic             is_data;
      logic [AddrW-1:0] addr;
      logic [2:0]       pos;
      logic             inv;
      logic             last;
   } sym_type;

   function automatic logic [IdxW-1:0] frame_len(input proto_type p);
      logic [IdxW-1:0] n;
      unique case (p)
         PROTO_LONG:   n = 9'd292;
         PROTO_NIBBLE: n = 9'd70;
         PROTO_MIRROR: n = 9'd100;
         default:      n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

### rtl/hvac_irfe_store.sv
module hvac_irfe_store (
   input  logic                                clock,
   input  hvac_irfe_pkg::wr_type               wr_port,
   input  logic                                rd_en,
   input  logic [hvac_irfe_pkg::AddrW-1:0]     rd_addr,
   output logic [7:0]                          rd_data
);
   import hvac_irfe_pkg::*;

   logic [7:0] frame_mem [FrameBytes];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         frame_mem[wr_port.addr] <= wr_port.data;
      end
      // read data holds until the next read, so a stalled symbol keeps its byte
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hvac_irfe_writer.sv
module hvac_irfe_writer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  hvac_irfe_pkg::req_type            req,
   output hvac_irfe_pkg::wr_type             wr_port,
   output logic [hvac_irfe_pkg::AddrW:0]     fill_count
);
   import hvac_irfe_pkg::*;

   localparam logic [AddrW:0] FillEnd = (AddrW + 1)'(FrameBytes);

   // fixed bytes of the long frame; both fixed-section checksums folded in
   localparam logic [7:0] BaseLong [FrameBytes] = '{
      8'h11, 8'hDA, 8'h27, 8'h00, 8'hC5, 8'h00, 8'h00, 8'hD7,
      8'h11, 8'hDA, 8'h27, 8'h00, 8'h42, 8'h00, 8'h00, 8'h54,
      8'h11, 8'hDA, 8'h27, 8'h00, 8'h00, 8'h49, 8'h1E, 8'h00,
      8'hB0, 8'h00, 8'h00, 8'h06, 8'h60, 8'h00, 8'h00, 8'hC0,
      8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      proto_type  proto;
      logic       pw;
      logic [2:0] mc;
      logic [1:0] fc;
      logic [5:0] c0;
      logic [3:0] c1;
      logic [4:0] foff;
      logic       model_one;
   } build_type;

   // 0 auto, 1 cool, 2 heat, 3 fan, 4 dry
   function automatic logic [2:0] mode_class(input logic [7:0] m);
      logic [2:0] r;
      case (m) inside
         8'd3, 8'd6: r = 3'd1;
         8'd4, 8'd5: r = 3'd2;
         8'd7:       r = 3'd3;
         8'd8, 8'd9: r = 3'd4;
         default:    r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] fan_class(input logic [7:0] f);
      logic [1:0] r;
      case (f) inside
         8'd1:       r = 2'd1;
         8'd2:       r = 2'd2;
         8'd3, 8'd4: r = 2'd3;
         default:    r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic logic [7:0] gen_byte(input build_type b, input logic [AddrW-1:0] a);
      logic [2:0] m0, m1, m2;
      logic [3:0] f0;
      logic [1:0] fan1;
      logic [7:0] b21, b22, b24, n0, n1, n2, v1, v2, res;
      case (b.mc)
         3'd1:    begin m0 = 3'd3; m1 = 3'd1; m2 = 3'd0; end
         3'd2:    begin m0 = 3'd4; m1 = 3'd4; m2 = 3'd3; end
         3'd3:    begin m0 = 3'd6; m1 = 3'd3; m2 = 3'd4; end
         3'd4:    begin m0 = 3'd2; m1 = 3'd2; m2 = 3'd1; end
         default: begin m0 = 3'd0; m1 = 3'd0; m2 = 3'd2; end
      endcase
      case (b.fc)
         2'd1:    f0 = 4'h3;
         2'd2:    f0 = 4'h5;
         2'd3:    f0 = 4'h7;
         default: f0 = 4'hA;
      endcase
      // dry mode forces the low fan on the nibble frame
      fan1 = (b.mc == 3'd4) ? 2'd1 : b.fc;
      b21 = {1'b0, m0, 1'b1, 2'b00, b.pw};
      b22 = {1'b0, b.c0, 1'b0};
      b24 = {f0, 4'h0};
      n0  = {2'b01, fan1, b.pw, m1};
      n1  = {4'h0, b.c1};
      n2  = {1'b0, b.pw & ~b.model_one, 1'b1, 5'b00000};
      v1  = 8'h80 | {3'b000, b.fc, 3'b000} | {6'b000000, b.pw, 1'b0} | {5'b00000, m2};
      v2  = 8'h60 | {3'b000, b.foff};
      res = 8'h00;
      case (b.proto)
         PROTO_LONG: begin
            case (a)
               6'd21:   res = b21;
               6'd22:   res = b22;
               6'd24:   res = b24;
               6'd25:   res = 8'h00;
               6'd34:   res = 8'h38 + b21 + b22 + b24;
               default: res = BaseLong[a];
            endcase
         end
         PROTO_NIBBLE: begin
            case (a)
               6'd0:    res = n0;
               6'd1:    res = n1;
               6'd2:    res = n2;
               6'd3:    res = 8'h50;
               6'd4:    res = 8'h01;
               6'd5:    res = 8'h20;
               6'd7:    res = {4'd12 + n0[3:0] + n1[3:0], 4'h0};
               default: res = 8'h00;
            endcase
         end
         PROTO_MIRROR: begin
            case (a)
               6'd0:    res = 8'hA1;
               6'd1:    res = v1;
               6'd2:    res = v2;
               6'd3:    res = 8'hFF;
               6'd4:    res = 8'hFF;
               6'd5:    res = rev8(8'h00 - (8'h83 + rev8(v1) + rev8(v2)));
               default: res = 8'h00;
            endcase
         end
         default: res = 8'h00;
      endcase
      return res;
   endfunction

   build_type       build_ff, build_in;
   logic [AddrW:0]  fill_ff, fill_in;
   logic [11:0]     tu;
   logic [24:0]     q_prod;
   logic [5:0]      q, c1_full;
   logic [14:0]     nine_t, x_full;
   logic [28:0]     f_prod;
   logic            below10, above32, below16, above30, below62, above86;

   // degrees by reciprocal multiply; only taken inside the unclamped range
   assign tu      = req.target_centi_c[11:0];
   assign q_prod  = {13'd0, tu} * 25'd5243;
   assign q       = q_prod[24:19];
   assign c1_full = q - 6'd16;
   assign nine_t  = {tu, 3'b000} + {3'b000, tu};
   assign x_full  = nine_t - 15'd14750;
   assign f_prod  = {15'd0, x_full[13:0]} * 29'd16778;

   assign below10 = req.target_centi_c < 16'sd1000;
   assign above32 = req.target_centi_c >= 16'sd3300;
   assign below16 = req.target_centi_c < 16'sd1600;
   assign above30 = req.target_centi_c >= 16'sd3100;
   assign below62 = req.target_centi_c < 16'sd1695;
   assign above86 = req.target_centi_c >= 16'sd2973;

   always_comb begin
      build_in.proto     = req.protocol;
      build_in.pw        = req.power_on;
      build_in.mc        = mode_class(req.mode_code);
      build_in.fc        = fan_class(req.fan_code);
      build_in.model_one = (req.variant_model == 8'd1);
      if (below10) begin
         build_in.c0 = 6'd10;
      end else if (above32) begin
         build_in.c0 = 6'd32;
      end else begin
         build_in.c0 = q;
      end
      // auto mode always sends 25 degrees
      if (build_in.mc == 3'd0) begin
         build_in.c1 = 4'd9;
      end else if (below16) begin
         build_in.c1 = 4'd0;
      end else if (above30) begin
         build_in.c1 = 4'd14;
      end else begin
         build_in.c1 = c1_full[3:0];
      end
      if (below62) begin
         build_in.foff = 5'd0;
      end else if (above86) begin
         build_in.foff = 5'd24;
      end else begin
         build_in.foff = f_prod[27:23];
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (start) begin
         fill_in = '0;
      end else if (fill_ff < FillEnd) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FillEnd;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         build_ff <= build_in;
      end
   end

   // one byte a cycle, in transmit order, well ahead of the bit reader
   assign wr_port.en   = fill_ff < FillEnd;
   assign wr_port.addr = fill_ff[AddrW-1:0];
   assign wr_port.data = gen_byte(build_ff, fill_ff[AddrW-1:0]);
   assign fill_count   = fill_ff;

endmodule

### rtl/hvac_irfe_decode.sv
module hvac_irfe_decode (
   input  hvac_irfe_pkg::proto_type             proto,
   input  logic [hvac_irfe_pkg::IdxW-1:0]       idx,
   output hvac_irfe_pkg::sym_type               sym
);
   import hvac_irfe_pkg::*;

   logic [IdxW-1:0]  st, k, d;
   logic [AddrW-1:0] first;
   logic [IdxW-1:0]  nbits;
   logic [7:0]       bit_no;
   logic             half;

   always_comb begin
      sym    = '0;
      st     = '0;
      k      = '0;
      d      = '0;
      first  = '0;
      nbits  = '0;
      bit_no = '0;
      half   = 1'b0;
      sym.last = ({1'b0, idx} + 10'd1) >= {1'b0, frame_len(proto)};
      unique case (proto)
         PROTO_LONG: begin
            sym.mark   = 14'd428;
            sym.space0 = 15'd428;
            sym.space1 = 15'd1280;
            if (idx == 9'd5) begin
               sym.space0 = 15'd29428;
            end else if (idx > 9'd5) begin
               if (idx < 9'd72) begin
                  st = 9'd6;   first = 6'd0;  nbits = 9'd64;
               end else if (idx < 9'd138) begin
                  st = 9'd72;  first = 6'd8;  nbits = 9'd64;
               end else begin
                  st = 9'd138; first = 6'd16; nbits = 9'd152;
               end
               k = idx - st;
               if (k == 9'd0) begin
                  sym.mark   = 14'd3650;
                  sym.space0 = 15'd1623;
               end else if (k > nbits) begin
                  sym.space0 = 15'd29428;
               end else begin
                  d           = k - 9'd1;
                  bit_no      = d[7:0];
                  sym.is_data = 1'b1;
                  sym.addr    = first + {1'b0, bit_no[7:3]};
                  sym.pos     = bit_no[2:0];
               end
            end
         end
         PROTO_NIBBLE: begin
            sym.mark   = 14'd620;
            sym.space0 = 15'd540;
            sym.space1 = 15'd1600;
            if (idx == 9'd0) begin
               sym.mark   = 14'd9000;
               sym.space0 = 15'd4500;
            end else if (idx <= 9'd32) begin
               d           = idx - 9'd1;
               sym.is_data = 1'b1;
               sym.addr    = {4'd0, d[4:3]};
               sym.pos     = d[2:0];
            end else if (idx == 9'd34) begin
               sym.space0 = 15'd1600;
            end else if (idx == 9'd36 || idx >= 9'd69) begin
               sym.space0 = 15'd19980;
            end else if (idx > 9'd36) begin
               d           = idx - 9'd37;
               sym.is_data = 1'b1;
               sym.addr    = 6'd4 + {4'd0, d[4:3]};
               sym.pos     = d[2:0];
            end
         end
         PROTO_MIRROR: begin
            // second half repeats the frame inverted
            half       = idx >= 9'd50;
            k          = half ? idx - 9'd50 : idx;
            sym.mark   = 14'd560;
            sym.space0 = 15'd560;
            sym.space1 = 15'd1680;
            if (k == 9'd0) begin
               sym.mark   = 14'd4480;
               sym.space0 = 15'd4480;
            end else if (k <= 9'd48) begin
               d           = k - 9'd1;
               sym.is_data = 1'b1;
               sym.addr    = {3'd0, d[5:3]};
               sym.pos     = ~d[2:0];
               sym.inv     = half;
            end else begin
               sym.space0 = 15'd5600;
            end
         end
         default: begin
            sym.last = 1'b1;
         end
      endcase
   end

endmodule

### rtl/hvac_ir_frame_encoder_unit.sv
// channel   dir  handshake              payload
// req       in   req_valid / req_stall  req_data  (hvac_irfe_pkg::req_type)
// rsp       out  rsp_valid / rsp_stall  rsp_data  (hvac_irfe_pkg::rsp_type)
//
// one request beat a cycle while req_stall is low; a symbol result is registered in
// the read stage and then the output register; the frame memory is filled one byte
// a cycle, all 35 bytes in transmit order, always ahead of the bit reads of the frame
// synchronous reset clears frame state and pipeline valids, and idles the fill counter
// rsp_stall holds the output register; one more result waits in the read stage,
// and req_stall rises only when both are full
module hvac_ir_frame_encoder_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hvac_irfe_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hvac_irfe_pkg::rsp_type  rsp_data
);
   import hvac_irfe_pkg::*;

   logic            accept, is_start, is_next, start_ok, start_err, emit, adv, rd_en;
   logic            active_ff, active_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   proto_type       active_proto_ff, active_proto_in;
   sym_type         sym, s1_sym_ff, s1_sym_in;
   logic            s1_valid_ff, s1_valid_in, s1_status_ff, s1_status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   wr_type          wr_port;
   logic [AddrW:0]  fill_count;
   logic [7:0]      rd_data;
   logic            bit_val;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;
   assign is_start  = accept && req_data.cmd == CMD_START;
   assign is_next   = accept && req_data.cmd == CMD_NEXT;
   assign start_ok  = is_start && req_data.protocol != PROTO_UNSUPPORTED;
   assign start_err = is_start && req_data.protocol == PROTO_UNSUPPORTED;
   assign emit      = is_next && active_ff;
   assign rd_en     = emit && sym.is_data;

   hvac_irfe_writer u_writer (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ok),
      .req        (req_data),
      .wr_port    (wr_port),
      .fill_count (fill_count)
   );

   hvac_irfe_store u_store (
      .clock   (clock),
      .wr_port (wr_port),
      .rd_en   (rd_en),
      .rd_addr (sym.addr),
      .rd_data (rd_data)
   );

   hvac_irfe_decode u_decode (
      .proto (active_proto_ff),
      .idx   (idx_ff),
      .sym   (sym)
   );

   always_comb begin
      idx_in          = idx_ff;
      active_in       = active_ff;
      active_proto_in = active_proto_ff;
      if (is_start) begin
         idx_in    = '0;
         active_in = start_ok;
         if (start_ok) begin
            active_proto_in = req_data.protocol;
         end
      end else if (emit) begin
         if (sym.last) begin
            active_in = 1'b0;
            idx_in    = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_sym_in    = sym;
      s1_status_in = STATUS_OK;
      if (start_err) begin
         s1_sym_in      = '0;
         s1_sym_in.last = 1'b1;
         s1_status_in   = STATUS_UNSUPPORTED;
      end
      s1_valid_in = s1_valid_ff;
      if (emit || start_err) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
   end

   assign bit_val = rd_data[s1_sym_ff.pos] ^ s1_sym_ff.inv;

   always_comb begin
      rsp_data_in.mark_us = s1_sym_ff.mark;
      rsp_data_in.off_us  = (s1_sym_ff.is_data && bit_val) ? s1_sym_ff.space1
                                                           : s1_sym_ff.space0;
      rsp_data_in.last    = s1_sym_ff.last;
      rsp_data_in.status  = s1_status_ff;
      rsp_valid_in        = adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff          <= '0;
         active_ff       <= 1'b0;
         active_proto_ff <= PROTO_LONG;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         idx_ff          <= idx_in;
         active_ff       <= active_in;
         active_proto_ff <= active_proto_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit || start_err) begin
         s1_sym_ff    <= s1_sym_in;
         s1_status_ff <= s1_status_in;
      end
      if (adv && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a bit read must find its byte already written by the fill
   a_read_after_fill: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({1'b0, sym.addr} < fill_count))
      else $error("frame byte read before it was written");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff < frame_len(active_proto_ff)))
      else $error("symbol index past end of frame");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      start_err |=> (s1_valid_ff && s1_status_ff == STATUS_UNSUPPORTED))
      else $error("unsupported start gave no error result");

   a_idle_next: assert property (@(posedge clock) disable iff (reset)
      (is_next && !active_ff) |=> !s1_valid_ff)
      else $error("next beat without a frame produced a result");

endmodule

### tb/testbench.sv
module testbench;
   import hvac_irfe_pkg::*;

   // mode and fan groups that the thermostat codes fold into
   typedef enum int {
      MC_AUTO = 0,
      MC_COOL = 1,
      MC_HEAT = 2,
      MC_FAN  = 3,
      MC_DRY  = 4
   } mode_group_type;

   typedef enum int {
      FG_AUTO = 0,
      FG_LOW  = 1,
      FG_MED  = 2,
      FG_HIGH = 3
   } fan_group_type;

   localparam int RandomItems = 1100;

   localparam logic [8*FrameBytes-1:0] LONG_TEMPLATE = {
      8'h11, 8'hDA, 8'h27, 8'h00, 8'hC5, 8'h00, 8'h00, 8'h00,
      8'h11, 8'hDA, 8'h27, 8'h00, 8'h42, 8'h00, 8'h00, 8'h00,
      8'h11, 8'hDA, 8'h27, 8'h00, 8'h00, 8'h49, 8'h1E, 8'h00,
      8'hB0, 8'h00, 8'h00, 8'h06, 8'h60, 8'h00, 8'h00, 8'hC0,
      8'h00, 8'h00, 8'h00
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_beats[$];
   rsp_type expected_symbols[$];

   // predicted encoder state
   logic [7:0] frame_mem [0:FrameBytes-1];
   int         sym_idx = 0;
   proto_type  cur_proto = PROTO_LONG;
   bit         frame_on = 1'b0;

   int total_beats = 0;
   int beats_in = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int error_count = 0;
   int symbols_checked = 0;
   int frame_starts = 0;
   int unsupported_starts = 0;
   int frames_done = 0;

   hvac_ir_frame_encoder_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic mode_group_type mode_group(input logic [7:0] m);
      mode_group_type g;
      case (m)
         8'd3, 8'd6: g = MC_COOL;
         8'd4, 8'd5: g = MC_HEAT;
         8'd7:       g = MC_FAN;
         8'd8, 8'd9: g = MC_DRY;
         default:    g = MC_AUTO;
      endcase
      return g;
   endfunction

   function automatic fan_group_type fan_group(input logic [7:0] f);
      fan_group_type g;
      case (f)
         8'd1:       g = FG_LOW;
         8'd2:       g = FG_MED;
         8'd3, 8'd4: g = FG_HIGH;
         default:    g = FG_AUTO;
      endcase
      return g;
   endfunction

   function automatic int clamp(input int v, input int lo, input int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [7:0] bit_reverse(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7-i] = v[i];
      return r;
   endfunction

   function automatic logic [7:0] byte_sum(input int from, input int n);
      int acc;
      acc = 0;
      for (int i = 0; i < n; i++) acc += frame_mem[from+i];
      return acc[7:0];
   endfunction

   function automatic int frame_symbols(input proto_type p);
      case (p)
         PROTO_LONG:   return 292;
         PROTO_NIBBLE: return 70;
         PROTO_MIRROR: return 100;
         default:      return 0;
      endcase
   endfunction

   function automatic void build_frame(input req_type r);
      int             centi;
      int             deg;
      int             fahr;
      int             acc;
      int             mbits;
      int             fbits;
      mode_group_type mg;
      fan_group_type  fg;
      mg = mode_group(r.mode_code);
      fg = fan_group(r.fan_code);
      centi = $signed(r.target_centi_c);
      deg = centi / 100;
      case (r.protocol)
         PROTO_LONG: begin
            case (mg)
               MC_COOL: mbits = 3;
               MC_HEAT: mbits = 4;
               MC_FAN:  mbits = 6;
               MC_DRY:  mbits = 2;
               default: mbits = 0;
            endcase
            case (fg)
               FG_LOW:  fbits = 'h3;
               FG_MED:  fbits = 'h5;
               FG_HIGH: fbits = 'h7;
               default: fbits = 'hA;
            endcase
            for (int i = 0; i < FrameBytes; i++)
               frame_mem[i] = LONG_TEMPLATE[8*(FrameBytes-1-i) +: 8];
            deg = clamp(deg, 10, 32);
            acc = ('h49 & 'h88) | int'(r.power_on) | (mbits << 4);
            frame_mem[21] = acc[7:0];
            acc = deg * 2;
            frame_mem[22] = acc[7:0];
            acc = fbits << 4;
            frame_mem[24] = acc[7:0];
            frame_mem[25] = 8'h00;
            frame_mem[7]  = byte_sum(0, 7);
            frame_mem[15] = byte_sum(8, 7);
            frame_mem[34] = byte_sum(16, 18);
         end
         PROTO_NIBBLE: begin
            case (mg)
               MC_COOL: mbits = 1;
               MC_HEAT: mbits = 4;
               MC_FAN:  mbits = 3;
               MC_DRY:  mbits = 2;
               default: mbits = 0;
            endcase
            deg = clamp(deg, 16, 30);
            if (mg == MC_AUTO) deg = 25;
            // dry always runs the low fan
            fbits = (mg == MC_DRY) ? int'(FG_LOW) : int'(fg);
            for (int i = 0; i < 8; i++) frame_mem[i] = 8'h00;
            acc = mbits | (int'(r.power_on) << 3) | (fbits << 4) | 'h40;
            frame_mem[0] = acc[7:0];
            acc = deg - 16;
            frame_mem[1] = acc[7:0];
            frame_mem[2] = 8'h20 | ((r.power_on && r.variant_model != 8'd1) ? 8'h40 : 8'h00);
            frame_mem[3] = 8'h50;
            frame_mem[4] = 8'h01;
            frame_mem[5] = 8'h20;
            frame_mem[6] = 8'h00;
            acc = 10;
            for (int i = 0; i < 4; i++) acc += frame_mem[i][3:0];
            for (int i = 4; i < 7; i++) acc += frame_mem[i][7:4];
            frame_mem[7] = {acc[3:0], 4'h0};
         end
         default: begin
            case (mg)
               MC_COOL: mbits = 0;
               MC_HEAT: mbits = 3;
               MC_FAN:  mbits = 4;
               MC_DRY:  mbits = 1;
               default: mbits = 2;
            endcase
            fahr = clamp((centi * 9 + 16250) / 500, 62, 86);
            frame_mem[0] = 8'hA1;
            acc = 'h80 | (int'(r.power_on) << 1) | (int'(fg) << 3) | mbits;
            frame_mem[1] = acc[7:0];
            acc = 'h60 | (fahr - 62);
            frame_mem[2] = acc[7:0];
            frame_mem[3] = 8'hFF;
            frame_mem[4] = 8'hFF;
            acc = 0;
            for (int i = 0; i < 5; i++) acc += bit_reverse(frame_mem[i]);
            acc = 0 - acc;
            frame_mem[5] = bit_reverse(acc[7:0]);
         end
      endcase
   endfunction

   function automatic bit frame_bit(input int b, input int k, input bit msb_first, input bit inv);
      int         idx;
      int         pos;
      logic [7:0] v;
      idx = b + k / 8;
      pos = msb_first ? 7 - (k % 8) : k % 8;
      v = (idx < FrameBytes) ? frame_mem[idx] : 8'h00;
      if (inv) v = ~v;
      return v[pos];
   endfunction

   function automatic void symbol_timing(input proto_type p, input int i,
                                         output int mk, output int sp);
      int start;
      int nbits;
      int k;
      int half;
      case (p)
         PROTO_LONG: begin
            mk = 428;
            sp = 428;
            if (i == 5) sp = 29428;
            else if (i > 5) begin
               for (int s = 0; s < 3; s++) begin
                  start = (s == 0) ? 6 : (s == 1) ? 72 : 138;
                  nbits = (s == 2) ? 152 : 64;
                  if (i >= start && i <= start + nbits + 1) begin
                     k = i - start;
                     if (k == 0) begin
                        mk = 3650;
                        sp = 1623;
                     end else if (k > nbits) begin
                        sp = 29428;
                     end else begin
                        sp = frame_bit(8 * s, k - 1, 1'b0, 1'b0) ? 1280 : 428;
                     end
                  end
               end
            end
         end
         PROTO_NIBBLE: begin
            mk = 620;
            if (i == 0) begin
               mk = 9000;
               sp = 4500;
            end else if (i <= 32) sp = frame_bit(0, i - 1, 1'b0, 1'b0) ? 1600 : 540;
            else if (i == 33 || i == 35) sp = 540;
            else if (i == 34) sp = 1600;
            else if (i == 36 || i >= 69) sp = 19980;
            else sp = frame_bit(4, i - 37, 1'b0, 1'b0) ? 1600 : 540;
         end
         default: begin
            // second half repeats the frame inverted
            half = (i >= 50) ? 1 : 0;
            k = i - half * 50;
            mk = 560;
            if (k == 0) begin
               mk = 4480;
               sp = 4480;
            end else if (k <= 48) sp = frame_bit(0, k - 1, 1'b1, half != 0) ? 1680 : 560;
            else sp = 5600;
         end
      endcase
   endfunction

   function automatic void encode_beat(input req_type r);
      rsp_type want;
      int      mk;
      int      sp;
      bit      fin;
      if (r.cmd == CMD_START) begin
         sym_idx = 0;
         frame_on = 1'b0;
         if (r.protocol == PROTO_UNSUPPORTED) begin
            want.mark_us = '0;
            want.off_us  = '0;
            want.last    = 1'b1;
            want.status  = STATUS_UNSUPPORTED;
            expected_symbols.push_back(want);
            unsupported_starts++;
         end else begin
            build_frame(r);
            cur_proto = r.protocol;
            frame_on = 1'b1;
            frame_starts++;
         end
      end else if (frame_on) begin
         symbol_timing(cur_proto, sym_idx, mk, sp);
         fin = (sym_idx + 1 >= frame_symbols(cur_proto));
         want.mark_us = mk[13:0];
         want.off_us  = sp[14:0];
         want.last    = fin;
         want.status  = STATUS_OK;
         expected_symbols.push_back(want);
         if (fin) begin
            frame_on = 1'b0;
            sym_idx = 0;
            frames_done++;
         end else begin
            sym_idx++;
         end
      end
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   function automatic req_type make_start(input proto_type p, input logic pw,
                                          input logic [7:0] sm, input logic [7:0] fm,
                                          input logic signed [15:0] t,
                                          input logic [7:0] model);
      req_type r;
      r.cmd            = CMD_START;
      r.protocol       = p;
      r.power_on       = pw;
      r.mode_code      = sm;
      r.fan_code       = fm;
      r.target_centi_c = t;
      r.variant_model  = model;
      return r;
   endfunction

   function automatic req_type make_next();
      logic [63:0] noise;
      req_type     r;
      noise = {$urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      r.cmd = CMD_NEXT;
      return r;
   endfunction

   // first third: slow sender, slower receiver; then swapped; then full rate
   always_comb begin
      if (beats_in < total_beats / 3) begin
         send_idle_pct = 34;
         recv_idle_pct = 70;
      end else if (beats_in < 2 * total_beats / 3) begin
         send_idle_pct = 70;
         recv_idle_pct = 34;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_beat(req_data);
            beats_in++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: unexpected beat: expected none, got %0d %0d last %0d status %0d",
                        $time, rsp_data.mark_us, rsp_data.off_us, rsp_data.last,
                        rsp_data.status);
               error_count++;
            end else begin
               want = expected_symbols.pop_front();
               check_field("mark_us", want.mark_us, rsp_data.mark_us);
               check_field("off_us", want.off_us, rsp_data.off_us);
               check_field("last", want.last, rsp_data.last);
               check_field("status", want.status, rsp_data.status);
               symbols_checked++;
            end
         end
      end
   end

   initial begin : stimulus
      int        counted;
      int        pick;
      int        len;
      int        n;
      proto_type p;
      req_type   r;

      // directed: ignored requests, errors, restarts and field extremes
      pending_beats.push_back(make_next());
      pending_beats.push_back(make_start(PROTO_UNSUPPORTED, 1'b1, 8'hFF, 8'hFF,
                                         16'sh7FFF, 8'hFF));
      pending_beats.push_back(make_next());
      pending_beats.push_back(make_start(PROTO_MIRROR, 1'b1, 8'd4, 8'd4, 16'sh7FFF, 8'h00));
      repeat (3) pending_beats.push_back(make_next());
      // restart over a frame in progress
      pending_beats.push_back(make_start(PROTO_NIBBLE, 1'b1, 8'd0, 8'd255, 16'sh8000, 8'd1));
      repeat (2) pending_beats.push_back(make_next());
      // error drops the frame, so the next request is ignored
      pending_beats.push_back(make_start(PROTO_UNSUPPORTED, 1'b0, 8'd0, 8'd0, 16'sh0000,
                                         8'h00));
      pending_beats.push_back(make_next());
      pending_beats.push_back(make_start(PROTO_LONG, 1'b0, 8'd9, 8'd3, 16'sd3299, 8'hAA));
      repeat (2) pending_beats.push_back(make_next());
      pending_beats.push_back(make_start(PROTO_NIBBLE, 1'b1, 8'd8, 8'd2, 16'sd1650, 8'd0));
      repeat (2) pending_beats.push_back(make_next());
      pending_beats.push_back(make_start(PROTO_MIRROR, 1'b0, 8'd255, 8'd0, 16'sh8000, 8'hFF));
      repeat (3) pending_beats.push_back(make_next());

      // random frames, half played out in full, the others cut short or overrun
      counted = 0;
      while (counted < RandomItems) begin
         pick = $urandom_range(0, 99);
         p = (pick < 25) ? PROTO_LONG : (pick < 60) ? PROTO_NIBBLE :
             (pick < 92) ? PROTO_MIRROR : PROTO_UNSUPPORTED;
         r = make_next();
         r.cmd = CMD_START;
         r.protocol = p;
         if ($urandom_range(0, 3) != 0) r.mode_code = 8'($urandom_range(0, 10));
         if ($urandom_range(0, 3) != 0) r.fan_code = 8'($urandom_range(0, 5));
         if ($urandom_range(0, 1) != 0) r.variant_model = 8'($urandom_range(0, 2));
         case ($urandom_range(0, 3))
            0:       ;
            3:       r.target_centi_c = 16'($urandom_range(900, 3400));
            default: r.target_centi_c = 16'($urandom_range(0, 5000) - 500);
         endcase
         pending_beats.push_back(r);
         counted++;
         len = frame_symbols(p);
         if (p == PROTO_UNSUPPORTED) begin
            if ($urandom_range(0, 3) == 0) pending_beats.push_back(make_next());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) n = len;
            else if (pick < 85) n = $urandom_range(0, (len < 60) ? len : 60);
            else n = len + $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               pending_beats.push_back(make_next());
               if (i < len) counted++;
            end
         end
      end
      total_beats = pending_beats.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d request beats: %0d frames started, %0d ran to the end, %0d unsupported",
               beats_in, frame_starts, frames_done, unsupported_starts);
      $display("checked %0d result beats under three idle patterns", symbols_checked);
      if (error_count == 0 && expected_symbols.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("testbench: errors");
      $finish;
   end

endmodule
